FILE: design/mfr_pkg.sv
package mfr_pkg;

	// Fixed field widths
	localparam int INDEX_W = 13;
	localparam int DATA_W  = 8;

	// Widest pixel position over the supported frame sizes (1024 x 512)
	localparam int POS_MAX_W = 19;

	// Work queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	// Input item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// Configuration register indexes
	localparam logic REG_FLIP_LONG  = 1'b0;
	localparam logic REG_FLIP_SHORT = 1'b1;

	// All-white native byte
	localparam logic [DATA_W-1:0] BYTE_WHITE = 8'hFF;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_READ,
		OP_READ_WHITE
	} entry_op_t;

	// One unit of work handed from front to back
	typedef struct packed {
		entry_op_t              op;
		logic [POS_MAX_W-1:0]   pos;     // first pixel position, or byte address for writes
		logic [DATA_W-1:0]      data;    // landscape byte for writes
		logic [3:0]             nvalid;  // pixels inside the frame, 1 to 8
		logic                   down;    // walk rows upward (short axis mirrored)
	} entry_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_PRD,
		F_FIX,
		F_POS,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RUN,
		B_FIN
	} back_state_t;

endpackage

FILE: design/mfr_front.sv
module mfr_front #(
	parameter int FRAME_WIDTH  = 296,
	parameter int FRAME_HEIGHT = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [mfr_pkg::INDEX_W-1:0]   byte_index,
	input  logic [mfr_pkg::DATA_W-1:0]    land_byte,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic                          cfg_data,
	output logic                          push,
	output mfr_pkg::entry_t               push_entry,
	input  logic                          q_full
);

	localparam int LAND_BYTES   = (FRAME_WIDTH * FRAME_HEIGHT + 7) / 8;
	localparam int NRB          = (FRAME_HEIGHT + 7) / 8;
	localparam int NATIVE_BYTES = FRAME_WIDTH * NRB;
	localparam int P_W          = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
	localparam int G_W          = $clog2(FRAME_WIDTH);
	localparam int Y_W          = $clog2(FRAME_HEIGHT);
	localparam int SH           = 14;
	localparam int RECIP        = (1 << SH) / NRB;

	localparam logic [14:0]    RECIP_C  = 15'(RECIP);
	localparam logic [7:0]     NRB_C    = 8'(NRB);
	localparam logic [16:0]    LAND_C   = 17'(LAND_BYTES);
	localparam logic [16:0]    NAT_C    = 17'(NATIVE_BYTES);
	localparam logic [G_W-1:0] W1_C     = G_W'(FRAME_WIDTH - 1);
	localparam logic [Y_W-1:0] H1_C     = Y_W'(FRAME_HEIGHT - 1);
	localparam logic [9:0]     H_C      = 10'(FRAME_HEIGHT);
	localparam logic [P_W-1:0] W_C      = P_W'(FRAME_WIDTH);

	mfr_pkg::front_state_t state_q, state_d;

	logic                          flip_long_q, flip_short_q;
	logic [mfr_pkg::INDEX_W-1:0]   n_q;
	logic [12:0]                   qe_q;
	logic [12:0]                   prod_q;
	logic [G_W-1:0]                x_q;
	logic [Y_W-1:0]                y0_q;
	logic [3:0]                    nvalid_q;
	logic                          down_q;
	logic [P_W-1:0]                pos_q;

	logic        accept;
	logic        wr_in_range, rd_in_range;
	logic [27:0] mul_full;
	logic [19:0] prod_full;
	logic [12:0] r_est;
	logic        fix;
	logic [12:0] g;
	logic [12:0] sb_full;
	logic [9:0]  s0;
	logic [9:0]  left;
	logic [G_W-1:0] x_d;
	logic [Y_W-1:0] y0_d;
	logic [3:0]  nvalid_d;

	assign accept      = in_valid && !in_stall;
	assign wr_in_range = {4'b0, byte_index} < LAND_C;
	assign rd_in_range = {4'b0, byte_index} < NAT_C;

	// Hold off new beats while a read is being classified or the queue is full
	assign in_stall = (state_q != mfr_pkg::F_IDLE) || q_full;

	// Quotient estimate by reciprocal, then one correction step
	assign mul_full  = {15'b0, n_q} * {13'b0, RECIP_C};
	assign prod_full = {7'b0, qe_q} * {12'b0, NRB_C};
	assign r_est     = n_q - prod_q;
	assign fix       = r_est >= {5'b0, NRB_C};
	assign g         = qe_q + {12'b0, fix};
	assign sb_full   = fix ? (r_est - {5'b0, NRB_C}) : r_est;
	assign s0        = {sb_full[6:0], 3'b000};
	assign left      = H_C - s0;

	// Map native column and short position to landscape coordinates
	assign x_d      = flip_long_q ? (W1_C - g[G_W-1:0]) : g[G_W-1:0];
	assign y0_d     = flip_short_q ? (H1_C - s0[Y_W-1:0]) : s0[Y_W-1:0];
	assign nvalid_d = (left >= 10'd8) ? 4'd8 : left[3:0];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_long_q  <= 1'b0;
			flip_short_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				mfr_pkg::REG_FLIP_LONG:  flip_long_q  <= cfg_data;
				mfr_pkg::REG_FLIP_SHORT: flip_short_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mfr_pkg::F_IDLE: begin
				if (accept && kind == mfr_pkg::KIND_READ && rd_in_range)
					state_d = mfr_pkg::F_MUL;
			end
			mfr_pkg::F_MUL: state_d = mfr_pkg::F_PRD;
			mfr_pkg::F_PRD: state_d = mfr_pkg::F_FIX;
			mfr_pkg::F_FIX: state_d = mfr_pkg::F_POS;
			mfr_pkg::F_POS: state_d = mfr_pkg::F_PUSH;
			mfr_pkg::F_PUSH: begin
				if (!q_full)
					state_d = mfr_pkg::F_IDLE;
			end
			default: state_d = mfr_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mfr_pkg::F_IDLE;
		else
			state_q <= state_d;
	end

	// Outputs: queue push and entry contents
	always_comb begin
		push              = 1'b0;
		push_entry.op     = mfr_pkg::OP_WRITE;
		push_entry.pos    = mfr_pkg::POS_MAX_W'(byte_index);
		push_entry.data   = land_byte;
		push_entry.nvalid = 4'd8;
		push_entry.down   = 1'b0;
		case (state_q)
			mfr_pkg::F_IDLE: begin
				if (accept) begin
					if (kind == mfr_pkg::KIND_WRITE) begin
						push = wr_in_range;
					end else if (!rd_in_range) begin
						push          = 1'b1;
						push_entry.op = mfr_pkg::OP_READ_WHITE;
					end
				end
			end
			mfr_pkg::F_PUSH: begin
				push              = !q_full;
				push_entry.op     = mfr_pkg::OP_READ;
				push_entry.pos    = mfr_pkg::POS_MAX_W'(pos_q);
				push_entry.nvalid = nvalid_q;
				push_entry.down   = down_q;
			end
			default: ;
		endcase
	end

	// Datapath registers of the read classification
	always_ff @(posedge clk) begin
		case (state_q)
			mfr_pkg::F_IDLE: n_q <= byte_index;
			mfr_pkg::F_MUL:  qe_q <= mul_full[26:14];
			mfr_pkg::F_PRD:  prod_q <= prod_full[12:0];
			mfr_pkg::F_FIX: begin
				x_q      <= x_d;
				y0_q     <= y0_d;
				nvalid_q <= nvalid_d;
				down_q   <= flip_short_q;
			end
			mfr_pkg::F_POS: pos_q <= P_W'(y0_q) * W_C + P_W'(x_q);
			default: ;
		endcase
	end

endmodule

FILE: design/mfr_queue.sv
module mfr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mfr_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output mfr_pkg::entry_t head,
	output logic            not_empty
);

	localparam int PTR_W = $clog2(mfr_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(mfr_pkg::QUEUE_DEPTH + 1);

	mfr_pkg::entry_t  slot_q [mfr_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(mfr_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = slot_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(mfr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(mfr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: design/mfr_back.sv
module mfr_back #(
	parameter int FRAME_WIDTH  = 296,
	parameter int FRAME_HEIGHT = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mfr_pkg::entry_t             head,
	input  logic                        not_empty,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mfr_pkg::DATA_W-1:0]  native_byte
);

	localparam int LAND_BYTES = (FRAME_WIDTH * FRAME_HEIGHT + 7) / 8;
	localparam int P_W        = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
	localparam int LA_W       = P_W - 3;

	localparam logic [P_W-1:0] W_C = P_W'(FRAME_WIDTH);

	mfr_pkg::back_state_t state_q, state_d;

	logic [mfr_pkg::DATA_W-1:0] mem [LAND_BYTES];
	logic [mfr_pkg::DATA_W-1:0] rdata_q;

	logic [P_W-1:0]  pos_q;
	logic [2:0]      k_q;
	logic [3:0]      nvalid_q;
	logic            down_q;
	logic [7:0]      acc_q;
	logic [2:0]      bit_s1, k_s1;
	logic            ok_s1;
	logic            out_valid_q;
	logic [7:0]      out_data_q;

	logic            start_rd, start_wr, start_white;
	logic            issue, iss_ok, iss_down;
	logic [P_W-1:0]  iss_pos, next_pos;
	logic [2:0]      iss_k;
	logic [3:0]      iss_nvalid;
	logic [7:0]      acc_next;
	logic            out_fire, load_white, load_acc;

	assign out_fire = out_valid_q && !out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mfr_pkg::B_IDLE: begin
				if (start_rd)
					state_d = mfr_pkg::B_RUN;
			end
			mfr_pkg::B_RUN: begin
				if (k_q == 3'd7)
					state_d = mfr_pkg::B_FIN;
			end
			mfr_pkg::B_FIN: state_d = mfr_pkg::B_IDLE;
			default: state_d = mfr_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mfr_pkg::B_IDLE;
		else
			state_q <= state_d;
	end

	// Outputs: pop, pixel read issue, result loads
	always_comb begin
		start_rd    = 1'b0;
		start_wr    = 1'b0;
		start_white = 1'b0;
		issue       = 1'b0;
		iss_pos     = pos_q;
		iss_k       = k_q;
		iss_nvalid  = nvalid_q;
		iss_down    = down_q;
		load_white  = 1'b0;
		load_acc    = 1'b0;
		case (state_q)
			mfr_pkg::B_IDLE: begin
				if (not_empty) begin
					case (head.op)
						mfr_pkg::OP_WRITE:      start_wr    = 1'b1;
						mfr_pkg::OP_READ:       start_rd    = !out_valid_q;
						mfr_pkg::OP_READ_WHITE: start_white = !out_valid_q;
						default: ;
					endcase
				end
				issue      = start_rd;
				iss_pos    = head.pos[P_W-1:0];
				iss_k      = 3'd0;
				iss_nvalid = head.nvalid;
				iss_down   = head.down;
				load_white = start_white;
			end
			mfr_pkg::B_RUN: issue = 1'b1;
			mfr_pkg::B_FIN: load_acc = 1'b1;
			default: ;
		endcase
	end

	assign pop      = start_rd || start_wr || start_white;
	assign iss_ok   = issue && ({1'b0, iss_k} < iss_nvalid);
	assign next_pos = iss_down ? (iss_pos - W_C) : (iss_pos + W_C);

	// Frame memory, single port
	always_ff @(posedge clk) begin
		if (start_wr)
			mem[head.pos[LA_W-1:0]] <= head.data;
		else if (iss_ok)
			rdata_q <= mem[iss_pos[P_W-1:3]];
	end

	// Clear the native bit where the landscape pixel is black
	always_comb begin
		acc_next = acc_q;
		if (ok_s1 && rdata_q[3'd7 - bit_s1])
			acc_next[3'd7 - k_s1] = 1'b0;
	end

	// Walk registers
	always_ff @(posedge clk) begin
		bit_s1 <= iss_pos[2:0];
		k_s1   <= iss_k;
		if (issue) begin
			pos_q <= next_pos;
			k_q   <= iss_k + 3'd1;
		end
		if (start_rd) begin
			nvalid_q <= head.nvalid;
			down_q   <= head.down;
			acc_q    <= mfr_pkg::BYTE_WHITE;
		end else begin
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ok_s1 <= 1'b0;
		else
			ok_s1 <= iss_ok;
	end

	// Output register: hold until the receiver takes the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_white || load_acc)
			out_valid_q <= 1'b1;
		else if (out_fire)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_white)
			out_data_q <= mfr_pkg::BYTE_WHITE;
		else if (load_acc)
			out_data_q <= acc_next;
	end

	assign out_valid   = out_valid_q;
	assign native_byte = out_data_q;

endmodule

FILE: design/mono_frame_rotate_flip_unit.sv
// One-bit-per-pixel landscape frame store with a rotated, inverted and
// optionally mirrored read port.
// Input channel (in_valid / in_stall): kind selects a write of land_byte at
// landscape address byte_index, or a read of native byte byte_index. Writes
// give no result; each read gives one native_byte beat on the output channel
// (out_valid / out_stall). Out-of-range writes are dropped, out-of-range
// reads return all white.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 sets
// flip_long, index 1 sets flip_short. Write only while the block is idle.
// Throughput: writes flow at one per cycle while the back end is idle and the
// front end is not classifying a read; they pass through the queue into the
// frame memory. A read holds the back end while it issues up to eight
// single-port frame memory reads (one per landscape row) and then drains; the
// next read starts only once the previous result beat has left. The front end
// classifies a read through its MUL, PRD, FIX, POS and PUSH states and
// overlaps with the back end through a two-entry queue.
// Reset clears control state and both flip registers; frame contents stay
// undefined until written. A stalled result holds in the output register;
// writes keep draining behind it, further reads wait.
module mono_frame_rotate_flip_unit #(
	parameter int FRAME_WIDTH  = 296,
	parameter int FRAME_HEIGHT = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [mfr_pkg::INDEX_W-1:0] byte_index,
	input  logic [mfr_pkg::DATA_W-1:0]  land_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mfr_pkg::DATA_W-1:0]  native_byte,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic                        cfg_data
);

	mfr_pkg::entry_t push_entry, head;
	logic            push, q_full, pop, not_empty;

	assign cfg_ready = 1'b1;

	mfr_front #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.byte_index (byte_index),
		.land_byte  (land_byte),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	mfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.not_empty  (not_empty)
	);

	mfr_back #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.not_empty   (not_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.native_byte (native_byte)
	);

endmodule
